/* hw/rtl/lc3s_pkg.sv */
// ============================================================================
// lc3s_pkg - shared types and constants for the lc3 instruction step core
// item and result layouts, opcodes, trap vectors, device addresses
// ============================================================================
`default_nettype none

package lc3s_pkg;

    // one queued word from the input side
    typedef struct packed {
        logic        op;
        logic [15:0] addr;
        logic [15:0] data;
        logic        key_ready;
        logic [7:0]  key_char;
    } t_item;

    // one result word
    typedef struct packed {
        logic        break_hit;
        logic        fault;
        logic        halted;
        logic [7:0]  out_char;
        logic        out_valid;
        logic [15:0] instr_word;
        logic [2:0]  cond_code;
        logic [15:0] pc_now;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MEM1,
        ST_MEM2
    } t_state;

    typedef enum logic [1:0] {
        SEL_MEM,
        SEL_KBSR,
        SEL_KBDR
    } t_rsel;

    localparam logic       OP_WRITE = 1'b0;
    localparam logic       OP_EXEC  = 1'b1;

    localparam logic [3:0] OPC_BR   = 4'h0;
    localparam logic [3:0] OPC_ADD  = 4'h1;
    localparam logic [3:0] OPC_LD   = 4'h2;
    localparam logic [3:0] OPC_ST   = 4'h3;
    localparam logic [3:0] OPC_JSR  = 4'h4;
    localparam logic [3:0] OPC_AND  = 4'h5;
    localparam logic [3:0] OPC_LDR  = 4'h6;
    localparam logic [3:0] OPC_STR  = 4'h7;
    localparam logic [3:0] OPC_RTI  = 4'h8;
    localparam logic [3:0] OPC_NOT  = 4'h9;
    localparam logic [3:0] OPC_LDI  = 4'hA;
    localparam logic [3:0] OPC_STI  = 4'hB;
    localparam logic [3:0] OPC_JMP  = 4'hC;
    localparam logic [3:0] OPC_RES  = 4'hD;
    localparam logic [3:0] OPC_LEA  = 4'hE;
    localparam logic [3:0] OPC_TRAP = 4'hF;

    localparam logic [7:0] VEC_GETC = 8'h20;
    localparam logic [7:0] VEC_OUT  = 8'h21;
    localparam logic [7:0] VEC_IN   = 8'h23;
    localparam logic [7:0] VEC_HALT = 8'h25;

    localparam logic [15:0] KBSR_ADDR   = 16'hFE00;
    localparam logic [15:0] KBDR_ADDR   = 16'hFE02;
    localparam logic [15:0] KEY_AVAIL   = 16'h8000;
    localparam logic [15:0] START_PC_RST = 16'h3000;

    localparam logic [2:0] CC_N = 3'b100;
    localparam logic [2:0] CC_Z = 3'b010;
    localparam logic [2:0] CC_P = 3'b001;

    localparam logic [1:0] CFG_START_PC  = 2'd0;
    localparam logic [1:0] CFG_BREAK_EN  = 2'd1;
    localparam logic [1:0] CFG_BREAK_ADR = 2'd2;

    function automatic logic [2:0] cc_of(input logic [15:0] v);
        logic [2:0] c;
        if (v == 16'd0) begin
            c = CC_Z;
        end else if (v[15]) begin
            c = CC_N;
        end else begin
            c = CC_P;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/lc3s_front.sv */
// ============================================================================
// lc3s_front - input side of the core
// accepts words and holds them in a two-entry queue for the back end
// ============================================================================
`default_nettype none

module lc3s_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire lc3s_pkg::t_item i_item,
    output logic                o_valid,
    input  wire logic           i_pop,
    output lc3s_pkg::t_item     o_item
);
    import lc3s_pkg::*;

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_item;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/lc3s_back.sv */
// ============================================================================
// lc3s_back - execution side of the core
// register file, pc, memory, sequencer and the result register
// ============================================================================
`default_nettype none

module lc3s_back #(
    parameter int ADDR_BITS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [15:0]      i_cfg_data,
    input  wire logic             i_q_valid,
    input  wire lc3s_pkg::t_item  i_q_item,
    output logic                  o_q_pop,
    output logic                  o_res_valid,
    input  wire logic             i_res_ready,
    output lc3s_pkg::t_result     o_res
);
    import lc3s_pkg::*;

    localparam int DEPTH = 2 ** ADDR_BITS;

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    t_state      r_state, n_state;
    t_item       r_item, n_item;
    logic [15:0] r_pc, n_pc;
    logic [2:0]  r_cc, n_cc;
    logic [15:0] r_regs [8];
    logic [15:0] n_regs [8];
    logic        r_halt, n_halt;
    logic [15:0] r_kbsr, n_kbsr, r_kbdr, n_kbdr;
    logic        r_brk_en;
    logic [15:0] r_brk_addr;
    logic [15:0] r_ra, n_ra;
    t_rsel       r_rsel, n_rsel;
    logic [15:0] r_instr, n_instr;
    logic        r_bhit, n_bhit;
    logic        r_ovalid, n_ovalid;
    t_result     r_res, n_res;

    logic        mem_we;
    logic [15:0] mem_wa, mem_wd;
    logic [15:0] rdv, ins;
    logic [3:0]  opc;
    logic [2:0]  dr, sr1;
    logic [15:0] va, vb, off9, off11, off6, v;
    logic        out_free, fin, fault;
    logic        ov;
    logic [7:0]  oc;
    logic        kr;
    logic [7:0]  kc;

    assign o_res_valid = r_ovalid;
    assign o_res       = r_res;
    assign out_free    = !r_ovalid || i_res_ready;

    // data returned by the last read, device words come from their registers
    always_comb begin
        case (r_rsel)
            SEL_KBSR: rdv = r_kbsr;
            SEL_KBDR: rdv = r_kbdr;
            default:  rdv = r_rdata;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_item   = r_item;
        n_pc     = r_pc;
        n_cc     = r_cc;
        n_regs   = r_regs;
        n_halt   = r_halt;
        n_kbsr   = r_kbsr;
        n_kbdr   = r_kbdr;
        n_ra     = r_ra;
        n_rsel   = r_rsel;
        n_instr  = r_instr;
        n_bhit   = r_bhit;
        n_ovalid = r_ovalid && !i_res_ready;
        n_res    = r_res;
        mem_we   = 1'b0;
        mem_wa   = r_item.addr;
        mem_wd   = r_item.data;
        o_q_pop  = 1'b0;
        fin      = 1'b0;
        fault    = 1'b0;
        ov       = 1'b0;
        oc       = 8'd0;
        v        = 16'd0;
        ins      = (r_state == ST_FETCH) ? rdv : r_instr;
        kr       = (r_state == ST_IDLE) ? i_q_item.key_ready : r_item.key_ready;
        kc       = (r_state == ST_IDLE) ? i_q_item.key_char : r_item.key_char;
        opc      = ins[15:12];
        dr       = ins[11:9];
        sr1      = ins[8:6];
        off9     = {{7{ins[8]}}, ins[8:0]};
        off11    = {{5{ins[10]}}, ins[10:0]};
        off6     = {{10{ins[5]}}, ins[5:0]};
        va       = r_regs[sr1];
        vb       = ins[5] ? {{11{ins[4]}}, ins[4:0]} : r_regs[ins[2:0]];

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_item.op == OP_EXEC && !r_halt) begin
                        o_q_pop = 1'b1;
                        n_item  = i_q_item;
                        n_bhit  = r_brk_en && (r_pc == r_brk_addr);
                        n_ra    = r_pc;
                        n_pc    = r_pc + 16'd1;
                        n_state = ST_FETCH;
                    end else if (out_free) begin
                        o_q_pop = 1'b1;
                        fin     = 1'b1;
                        n_instr = 16'd0;
                        n_bhit  = 1'b0;
                        if (i_q_item.op == OP_WRITE) begin
                            mem_we = 1'b1;
                            mem_wa = i_q_item.addr;
                            mem_wd = i_q_item.data;
                        end else begin
                            fault = 1'b1;
                        end
                    end
                end
            end
            ST_FETCH: begin
                n_instr = ins;
                case (opc)
                    OPC_LD, OPC_LDI, OPC_STI: begin
                        n_ra    = r_pc + off9;
                        n_state = ST_MEM1;
                    end
                    OPC_LDR: begin
                        n_ra    = va + off6;
                        n_state = ST_MEM1;
                    end
                    default: begin
                        if (out_free) begin
                            fin     = 1'b1;
                            n_state = ST_IDLE;
                            case (opc)
                                OPC_ADD, OPC_AND, OPC_NOT, OPC_LEA: begin
                                    case (opc)
                                        OPC_ADD: v = va + vb;
                                        OPC_AND: v = va & vb;
                                        OPC_NOT: v = ~va;
                                        default: v = r_pc + off9;
                                    endcase
                                    n_regs[dr] = v;
                                    n_cc       = cc_of(v);
                                end
                                OPC_BR: begin
                                    if ((dr & r_cc) != 3'd0) begin
                                        n_pc = r_pc + off9;
                                    end
                                end
                                OPC_JMP: n_pc = va;
                                OPC_JSR: begin
                                    n_regs[7] = r_pc;
                                    n_pc      = ins[11] ? r_pc + off11 : va;
                                end
                                OPC_ST, OPC_STR: begin
                                    mem_we = 1'b1;
                                    mem_wa = (opc == OPC_ST) ? r_pc + off9 : va + off6;
                                    mem_wd = r_regs[dr];
                                end
                                OPC_TRAP: begin
                                    n_regs[7] = r_pc;
                                    case (ins[7:0])
                                        VEC_GETC: begin
                                            n_regs[0] = {8'd0, kc};
                                            n_cc      = cc_of({8'd0, kc});
                                        end
                                        VEC_OUT: begin
                                            ov = 1'b1;
                                            oc = r_regs[0][7:0];
                                        end
                                        VEC_IN: begin
                                            ov        = 1'b1;
                                            oc        = kc;
                                            n_regs[0] = {8'd0, kc};
                                            n_cc      = cc_of({8'd0, kc});
                                        end
                                        VEC_HALT: n_halt = 1'b1;
                                        default:  n_halt = r_halt;
                                    endcase
                                end
                                default: fault = 1'b1;
                            endcase
                        end
                    end
                endcase
            end
            ST_MEM1: begin
                if (opc == OPC_LDI) begin
                    n_ra    = rdv;
                    n_state = ST_MEM2;
                end else if (out_free) begin
                    fin     = 1'b1;
                    n_state = ST_IDLE;
                    if (opc == OPC_STI) begin
                        mem_we = 1'b1;
                        mem_wa = rdv;
                        mem_wd = r_regs[dr];
                    end else begin
                        n_regs[dr] = rdv;
                        n_cc       = cc_of(rdv);
                    end
                end
            end
            ST_MEM2: begin
                if (out_free) begin
                    fin        = 1'b1;
                    n_state    = ST_IDLE;
                    n_regs[dr] = rdv;
                    n_cc       = cc_of(rdv);
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // entering a read state selects the read source, and refreshes the keyboard words when it hits status
        if (n_ra != r_ra || r_state != n_state) begin
            if (n_state == ST_FETCH || n_state == ST_MEM1 || n_state == ST_MEM2) begin
                if (r_state != n_state) begin
                    if (n_ra == KBSR_ADDR) begin
                        n_rsel = SEL_KBSR;
                        n_kbsr = kr ? KEY_AVAIL : 16'd0;
                        if (kr) begin
                            n_kbdr = {8'd0, kc};
                        end
                    end else if (n_ra == KBDR_ADDR) begin
                        n_rsel = SEL_KBDR;
                    end else begin
                        n_rsel = SEL_MEM;
                    end
                end
            end
        end

        // stores to the device addresses land in the device registers too
        if (mem_we && mem_wa == KBSR_ADDR) begin
            n_kbsr = mem_wd;
        end
        if (mem_we && mem_wa == KBDR_ADDR) begin
            n_kbdr = mem_wd;
        end

        if (i_cfg_we && i_cfg_index == CFG_START_PC) begin
            n_pc = i_cfg_data;
        end

        if (fin) begin
            n_ovalid         = 1'b1;
            n_res.pc_now     = n_pc;
            n_res.cond_code  = n_cc;
            n_res.instr_word = n_instr;
            n_res.out_valid  = ov;
            n_res.out_char   = oc;
            n_res.halted     = n_halt;
            n_res.fault      = fault;
            n_res.break_hit  = n_bhit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pc       <= START_PC_RST;
            r_cc       <= CC_Z;
            r_halt     <= 1'b0;
            r_ovalid   <= 1'b0;
            r_brk_en   <= 1'b0;
            r_brk_addr <= 16'd0;
            r_rsel     <= SEL_MEM;
            for (int i = 0; i < 8; i++) begin
                r_regs[i] <= 16'd0;
            end
        end else begin
            r_state  <= n_state;
            r_pc     <= n_pc;
            r_cc     <= n_cc;
            r_halt   <= n_halt;
            r_ovalid <= n_ovalid;
            r_rsel   <= n_rsel;
            r_regs   <= n_regs;
            if (i_cfg_we && i_cfg_index == CFG_BREAK_EN) begin
                r_brk_en <= i_cfg_data[0];
            end
            if (i_cfg_we && i_cfg_index == CFG_BREAK_ADR) begin
                r_brk_addr <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_kbsr  <= n_kbsr;
        r_kbdr  <= n_kbdr;
        r_ra    <= n_ra;
        r_instr <= n_instr;
        r_bhit  <= n_bhit;
        r_res   <= n_res;
    end

    // main memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa[ADDR_BITS-1:0]] <= mem_wd;
        end
        r_rdata <= r_mem[n_ra[ADDR_BITS-1:0]];
    end

endmodule

`default_nettype wire

/* hw/rtl/lc3_instruction_step.sv */
// ============================================================================
// lc3_instruction_step - lc3 core that loads or executes one word per item
// front queue takes words, back end runs the instruction against memory
// ============================================================================
//
//  channel   dir  handshake               contents
//  s_axis    in   s_axis_tvalid/tready    tuser: op; tdata: addr, data, key
//  m_axis    out  m_axis_tvalid/tready    tdata: one result per input word
//  cfg       in   i_cfg_we                i_cfg_index, i_cfg_data
//
//  steps: write word and halted step end in idle, most instructions in fetch,
//          ld/ldr/st-indirect after one memory read, ldi after two; reads are registered
//  a two-entry queue keeps taking words while the back end works, until it is full
//  reset clears pc to 0x3000, condition code to z, registers, halt and queues
//  a full result register stalls the back end at its last step only
//
`default_nettype none

module lc3_instruction_step #(
    parameter int ADDR_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // addr, data, key_ready, key_char, zero pad
    input  wire logic        s_axis_tuser,  // op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,  // pc_now, cond_code, instr_word, out_valid,
                                            // out_char, halted, fault, break_hit, pad
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import lc3s_pkg::*;

    t_item   w_in_item, w_q_item;
    logic    w_q_valid, w_q_pop;
    t_result w_res;

    // unpack the incoming word
    assign w_in_item.op        = s_axis_tuser;
    assign w_in_item.addr      = s_axis_tdata[15:0];
    assign w_in_item.data      = s_axis_tdata[31:16];
    assign w_in_item.key_ready = s_axis_tdata[32];
    assign w_in_item.key_char  = s_axis_tdata[40:33];

    lc3s_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_in_item),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_item  (w_q_item)
    );

    lc3s_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (w_res)
    );

    // pack the result word, first field lowest
    assign m_axis_tdata = {1'b0, w_res.break_hit, w_res.fault, w_res.halted,
                           w_res.out_char, w_res.out_valid, w_res.instr_word,
                           w_res.cond_code, w_res.pc_now};

    // a character never goes out together with a fault
    a_no_char_on_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(w_res.fault && w_res.out_valid))
        else $error("character output with fault");

    // a halted core never emits a character
    a_no_char_when_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_res.halted |-> !w_res.out_valid)
        else $error("character output while halted");

    // input side only stalls when the queue holds words
    a_stall_means_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> w_q_valid)
        else $error("input stalled with empty queue");

    // condition code is always a single flag
    a_cc_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $onehot(w_res.cond_code))
        else $error("condition code not one-hot");

endmodule

`default_nettype wire
